// ===== rtl/text_byte_visualizer_defines.svh =====
// Assertion macros used by the text byte visualizer back end.
// Define ASSERT_OFF to compile the checks out.
`ifndef TEXT_BYTE_VISUALIZER_DEFINES_SVH
`define TEXT_BYTE_VISUALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TBV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tbv assertion failed");
`define TBV_ASSERT_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("tbv assertion failed");
`else
`define TBV_ASSERT(lbl, clk, rst, prop)
`define TBV_ASSERT_NEVER(lbl, clk, rst, prop)
`endif

`endif

// ===== rtl/tbv_pkg.sv =====
package tbv_pkg;

  localparam int NUMBER_DIGITS = 7;
  localparam int COUNT_W       = 24;
  localparam longint COUNT_CAP = (64'd1 << COUNT_W) - 64'd1;

  function automatic longint count_limit_f();
    longint lim;
    lim = 1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      lim = lim * 10;
    end
    lim = lim - 1;
    if (lim > COUNT_CAP) begin
      lim = COUNT_CAP;
    end
    return lim;
  endfunction

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(count_limit_f());

  // Output slots of one queued entry, emitted from the lowest index upwards.
  localparam int TAB_SLOT  = NUMBER_DIGITS;
  localparam int PRE_SLOT  = NUMBER_DIGITS + 1;
  localparam int M_SLOT    = NUMBER_DIGITS + 2;
  localparam int DASH_SLOT = NUMBER_DIGITS + 3;
  localparam int HAT_SLOT  = NUMBER_DIGITS + 4;
  localparam int CH_SLOT   = NUMBER_DIGITS + 5;
  localparam int LF_SLOT   = NUMBER_DIGITS + 6;
  localparam int SLOT_N    = NUMBER_DIGITS + 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_INDEX_W = 4;

  localparam logic [7:0] CHR_TAB    = 8'd9;
  localparam logic [7:0] CHR_LF     = 8'd10;
  localparam logic [7:0] CHR_CR     = 8'd13;
  localparam logic [7:0] CHR_SPACE  = 8'd32;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_DASH   = 8'h2D;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_QUERY  = 8'h3F;
  localparam logic [7:0] CHR_M      = 8'h4D;
  localparam logic [7:0] CHR_HAT    = 8'h5E;
  localparam logic [7:0] CHR_DEL    = 8'd127;
  localparam logic [7:0] CARET_OFS  = 8'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DROP_CR          = 4'd0,
    REG_ADD_CR_BEFORE_LF = 4'd1,
    REG_ADD_LF_AFTER_CR  = 4'd2,
    REG_SHOW_NONPRINTING = 4'd3,
    REG_SHOW_META        = 4'd4,
    REG_SHOW_TABS        = 4'd5,
    REG_SHOW_ENDS        = 4'd6,
    REG_NUMBER_LINES     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic drop_cr;
    logic add_cr_before_lf;
    logic add_lf_after_cr;
    logic show_nonprinting;
    logic show_meta;
    logic show_tabs;
    logic show_ends;
    logic number_lines;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Digit 0 is the most significant.
  typedef struct packed {
    logic [SLOT_N-1:0]              mask;
    logic [NUMBER_DIGITS-1:0][3:0]  digits;
    logic [7:0]                     pre_byte;
    logic [7:0]                     ch;
  } q_entry_t;

endpackage

// ===== rtl/text_byte_visualizer.sv =====
// Text byte visualizer: converts a byte stream for display, one input byte
// giving zero to twelve output bytes (line number prefix, caret and meta
// notation, end marks, CR and LF insertion or removal).
// Input queue: an item (data_byte, file_start) is taken at a clock edge with
// push high and full low. Result queue: the oldest output byte sits on result
// while empty is low and is taken at an edge with pop high.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (indexes 8 and above are ignored); write only while the block is idle.
// The first byte of an accepted item is written into the queue and then into
// the result register before it is on result.
// Throughput: one result byte per cycle out of the back end while pop keeps
// the result taken, so an item with k results stays at the head of the queue
// until its k bytes are out; the front takes one item per cycle while its
// four-entry queue has room. Items giving no output bytes take no queue slot.
// When pop stays low the result is held, the queue fills and full then
// stalls the input. Reset clears the registers, the line count and the
// queues, and puts the stream at the start of a line.
module text_byte_visualizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  tbv_pkg::in_item_t               item,
  output logic                            empty,
  input  logic                            pop,
  output tbv_pkg::out_item_t              result,
  input  logic                            cfg_we,
  input  logic [tbv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_data
);
  import tbv_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     head_valid;
  q_entry_t q_entry;
  q_entry_t head;

  assign full = q_full;

  tbv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (q_full),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  tbv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wr_entry   (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tbv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== rtl/tbv_front.sv =====
module tbv_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          q_full,
  input  tbv_pkg::in_item_t             item,
  input  logic                          cfg_we,
  input  logic [tbv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  output logic                          q_push,
  output tbv_pkg::q_entry_t             q_entry
);
  import tbv_pkg::*;

  cfg_t                          cfg;
  logic                          at_line_start;
  logic [COUNT_W-1:0]            line_count;
  logic [NUMBER_DIGITS-1:0][3:0] bcd;

  logic                          at_line_start_next;
  logic [COUNT_W-1:0]            line_count_next;
  logic [NUMBER_DIGITS-1:0][3:0] bcd_next;

  logic       accept;
  logic       np;
  logic       number;
  logic       dropped;
  logic       pre_dollar;
  logic       pre_cr;
  logic       meta;
  logic       caret;
  logic       del;
  logic       lf_after;
  logic       carry;
  logic [7:0] c1;
  logic [7:0] ch;
  logic [SLOT_N-1:0] mask;

  assign accept = push && !q_full;

  always_comb begin
    np         = cfg.show_nonprinting;
    number     = cfg.number_lines && (item.file_start || at_line_start);
    dropped    = (item.data_byte == CHR_CR) && cfg.drop_cr;
    pre_dollar = (item.data_byte == CHR_CR) && np && cfg.show_ends;
    pre_cr     = (item.data_byte == CHR_LF) && cfg.add_cr_before_lf;
    meta       = item.data_byte[7] && np && cfg.show_meta;
    c1         = meta ? {1'b0, item.data_byte[6:0]} : item.data_byte;
    caret      = np && (c1 != 8'd0) && (c1 < CHR_SPACE) && (c1 != CHR_CR) &&
                 (c1 != CHR_LF) && (cfg.show_tabs || (c1 != CHR_TAB));
    del        = np && (c1 == CHR_DEL);
    ch         = caret ? (c1 + CARET_OFS) : (del ? CHR_QUERY : c1);
    lf_after   = (ch == CHR_CR) && cfg.add_lf_after_cr;

    // The binary count guards saturation, the decimal copy feeds the digits.
    line_count_next = line_count;
    bcd_next        = bcd;
    carry           = 1'b1;
    if (number && (line_count < COUNT_LIMIT)) begin
      line_count_next = line_count + COUNT_W'(1);
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
        if (carry) begin
          if (bcd[i] == 4'd9) begin
            bcd_next[i] = 4'd0;
          end else begin
            bcd_next[i] = bcd[i] + 4'd1;
            carry       = 1'b0;
          end
        end
      end
    end

    mask = '0;
    mask[TAB_SLOT:0] = {(NUMBER_DIGITS + 1){number}};
    if (!dropped) begin
      mask[PRE_SLOT]  = pre_dollar || pre_cr;
      mask[M_SLOT]    = meta;
      mask[DASH_SLOT] = meta;
      mask[HAT_SLOT]  = caret || del;
      mask[CH_SLOT]   = 1'b1;
      mask[LF_SLOT]   = lf_after;
    end

    // A dropped CR with only a number prefix ends on the tab, not a new line.
    at_line_start_next = !dropped && (lf_after || (ch == CHR_LF));

    q_entry.mask     = mask;
    q_entry.digits   = bcd_next;
    q_entry.pre_byte = pre_dollar ? CHR_DOLLAR : CHR_CR;
    q_entry.ch       = ch;
  end

  assign q_push = accept && (mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg           <= '0;
      at_line_start <= 1'b1;
      line_count    <= '0;
      bcd           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DROP_CR:          cfg.drop_cr          <= cfg_data;
          REG_ADD_CR_BEFORE_LF: cfg.add_cr_before_lf <= cfg_data;
          REG_ADD_LF_AFTER_CR:  cfg.add_lf_after_cr  <= cfg_data;
          REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data;
          REG_SHOW_META:        cfg.show_meta        <= cfg_data;
          REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data;
          REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data;
          REG_NUMBER_LINES:     cfg.number_lines     <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        at_line_start <= at_line_start_next;
        line_count    <= line_count_next;
        bcd           <= bcd_next;
      end
    end
  end

endmodule

// ===== rtl/tbv_queue.sv =====
module tbv_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tbv_pkg::q_entry_t wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tbv_pkg::q_entry_t head
);
  import tbv_pkg::*;

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/tbv_back.sv =====
`include "text_byte_visualizer_defines.svh"

module tbv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  tbv_pkg::q_entry_t  head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output tbv_pkg::out_item_t result
);
  import tbv_pkg::*;

  logic [SLOT_N-1:0] done;
  logic              out_valid;
  out_item_t         out_data;

  logic [SLOT_N-1:0] rem;
  logic [SLOT_N-1:0] cur;
  logic              last;
  logic              advance;
  logic              lead;
  logic [7:0]        slot_byte [SLOT_N];
  logic [7:0]        sel_byte;

  always_comb begin
    rem  = head.mask & ~done;
    cur  = rem & (~rem + SLOT_N'(1));
    last = ((rem & ~cur) == '0);

    // Leading zeros of the line number show as spaces, the units digit never.
    lead = 1'b1;
    for (int j = 0; j < NUMBER_DIGITS; j++) begin
      lead = lead && (head.digits[j] == 4'd0);
      if (lead && (j != NUMBER_DIGITS - 1)) begin
        slot_byte[j] = CHR_SPACE;
      end else begin
        slot_byte[j] = CHR_ZERO | {4'd0, head.digits[j]};
      end
    end
    slot_byte[TAB_SLOT]  = CHR_TAB;
    slot_byte[PRE_SLOT]  = head.pre_byte;
    slot_byte[M_SLOT]    = CHR_M;
    slot_byte[DASH_SLOT] = CHR_DASH;
    slot_byte[HAT_SLOT]  = CHR_HAT;
    slot_byte[CH_SLOT]   = head.ch;
    slot_byte[LF_SLOT]   = CHR_LF;

    sel_byte = '0;
    for (int i = 0; i < SLOT_N; i++) begin
      sel_byte = sel_byte | (cur[i] ? slot_byte[i] : 8'd0);
    end
  end

  assign advance = head_valid && (!out_valid || pop);
  assign q_pop   = advance && last;
  assign empty   = !out_valid;
  assign result  = out_data;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_byte    <= sel_byte;
      out_data.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        done <= last ? '0 : (done | cur);
      end
    end
  end

  `TBV_ASSERT(a_cur_onehot, clk, rst, head_valid |-> $onehot(cur))
  `TBV_ASSERT(a_done_in_mask, clk, rst, head_valid |-> ((done & ~head.mask) == '0))
  `TBV_ASSERT(a_done_cleared, clk, rst, q_pop |=> (done == '0))
  `TBV_ASSERT_NEVER(a_no_stale_done, clk, rst, !head_valid && (done != '0))

endmodule

// ===== tb/tb_text_byte_visualizer.sv =====
module tb_text_byte_visualizer;
  timeunit 1ns;
  timeprecision 1ps;

  import tbv_pkg::*;

  localparam int LINE_COUNT_W   = 24;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 200;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 20;

  localparam logic [7:0] ASC_TAB     = 8'd9;
  localparam logic [7:0] ASC_LF      = 8'd10;
  localparam logic [7:0] ASC_CR      = 8'd13;
  localparam logic [7:0] ASC_SPACE   = 8'd32;
  localparam logic [7:0] ASC_DOLLAR  = "$";
  localparam logic [7:0] ASC_DASH    = "-";
  localparam logic [7:0] ASC_ZERO    = "0";
  localparam logic [7:0] ASC_QUERY   = "?";
  localparam logic [7:0] ASC_M       = "M";
  localparam logic [7:0] ASC_CARET   = "^";
  localparam logic [7:0] ASC_DEL     = 8'd127;
  localparam logic [7:0] META_BIT    = 8'd128;
  localparam logic [7:0] CARET_SHIFT = 8'd64;

  // Predicts the output bytes of each accepted input byte and holds them until they arrive.
  class render_checker;
    cfg_t                    regs;
    bit                      at_line_start;
    logic [LINE_COUNT_W-1:0] line_no;
    logic [LINE_COUNT_W-1:0] line_cap;
    out_item_t               pending_bytes[$];
    int                      fails;
    int                      checked;

    function new();
      longint lim;
      lim = 1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        lim = lim * 10;
      end
      lim = lim - 1;
      if (lim > (longint'(1) << LINE_COUNT_W) - 1) begin
        lim = (longint'(1) << LINE_COUNT_W) - 1;
      end
      line_cap      = LINE_COUNT_W'(lim);
      regs          = '0;
      at_line_start = 1'b1;
      line_no       = '0;
      fails         = 0;
      checked       = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic v);
      case (idx)
        REG_DROP_CR:          regs.drop_cr = v;
        REG_ADD_CR_BEFORE_LF: regs.add_cr_before_lf = v;
        REG_ADD_LF_AFTER_CR:  regs.add_lf_after_cr = v;
        REG_SHOW_NONPRINTING: regs.show_nonprinting = v;
        REG_SHOW_META:        regs.show_meta = v;
        REG_SHOW_TABS:        regs.show_tabs = v;
        REG_SHOW_ENDS:        regs.show_ends = v;
        REG_NUMBER_LINES:     regs.number_lines = v;
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] b);
      pending_bytes.push_back('{out_byte: b, last_of_run: 1'b0});
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0]              orig;
      logic [7:0]              ch;
      logic [7:0]              last_b;
      logic [LINE_COUNT_W-1:0] v;
      logic [7:0]              digs[NUMBER_DIGITS];
      bit                      np;
      int                      first;
      orig   = it.data_byte;
      ch     = orig;
      np     = regs.show_nonprinting;
      last_b = '0;
      first  = pending_bytes.size();
      if (it.file_start) begin
        at_line_start = 1'b1;
      end
      if (regs.number_lines && at_line_start) begin
        if (line_no < line_cap) begin
          line_no = line_no + 1'b1;
        end
        v = line_no;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
          if (v == 0 && i != NUMBER_DIGITS - 1) begin
            digs[i] = ASC_SPACE;
          end else begin
            digs[i] = ASC_ZERO + 8'(v % 10);
            v = v / 10;
          end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
          emit(digs[i]);
        end
        emit(ASC_TAB);
        last_b = ASC_TAB;
      end
      if (!(orig == ASC_CR && regs.drop_cr)) begin
        if (orig == ASC_CR && np && regs.show_ends) begin
          emit(ASC_DOLLAR);
        end
        if (orig == ASC_LF && regs.add_cr_before_lf) begin
          emit(ASC_CR);
        end
        if (ch >= META_BIT && np && regs.show_meta) begin
          emit(ASC_M);
          emit(ASC_DASH);
          ch = ch - META_BIT;
        end
        if (np && ch > 0 && ch < ASC_SPACE && ch != ASC_CR && ch != ASC_LF &&
            (regs.show_tabs || ch != ASC_TAB)) begin
          emit(ASC_CARET);
          ch = ch + CARET_SHIFT;
        end
        if (np && ch == ASC_DEL) begin
          emit(ASC_CARET);
          ch = ASC_QUERY;
        end
        emit(ch);
        last_b = ch;
        if (ch == ASC_CR && regs.add_lf_after_cr) begin
          emit(ASC_LF);
          last_b = ASC_LF;
        end
      end
      // A byte that produces nothing at all still clears the line start.
      at_line_start = (pending_bytes.size() > first) && (last_b == ASC_LF);
      if (pending_bytes.size() > first) begin
        pending_bytes[pending_bytes.size() - 1].last_of_run = 1'b1;
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      checked++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0h last_of_run %0b",
               got.out_byte, got.last_of_run);
        fails++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
          fails++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
          fails++;
        end
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  in_item_t               item;
  logic                   empty;
  logic                   pop;
  out_item_t              result;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic                   cfg_data;

  render_checker sb;
  bit            quiet;
  int            hold_cycles;
  int            bytes_sent;
  int            settings_used;
  int            idle_cycles;

  text_byte_visualizer uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Mostly text lines with random content, laced with control and meta bytes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6: return 8'($urandom_range(33, 126));
      7:                   return ASC_SPACE;
      8, 9:                return ASC_LF;
      10:                  return ASC_CR;
      11:                  return ASC_TAB;
      12:                  return ASC_DEL;
      13:                  return 8'($urandom_range(128, 255));
      14:                  return 8'($urandom_range(0, 31));
      default:             return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic fs);
    in_item_t it;
    it = '{data_byte: b, file_start: fs};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  // Stops offering and waits until the block has nothing left in flight.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_cfg(cfg_t c, bit spare_write);
    write_reg(REG_DROP_CR, c.drop_cr);
    write_reg(REG_ADD_CR_BEFORE_LF, c.add_cr_before_lf);
    write_reg(REG_ADD_LF_AFTER_CR, c.add_lf_after_cr);
    write_reg(REG_SHOW_NONPRINTING, c.show_nonprinting);
    write_reg(REG_SHOW_META, c.show_meta);
    write_reg(REG_SHOW_TABS, c.show_tabs);
    write_reg(REG_SHOW_ENDS, c.show_ends);
    write_reg(REG_NUMBER_LINES, c.number_lines);
    // Writes above the last register must leave every setting alone.
    if (spare_write) begin
      write_reg(CFG_INDEX_W'(REG_NUMBER_LINES + 1 + $urandom_range(0, 7)), 1'b1);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int n;
    pop <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
        if (empty === 1'b0) begin
          sb.check_byte(result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && full === 1'b0) || (pop && empty === 1'b0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** text_byte_visualizer: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [7:0] mixed[14];
    cfg_t       c;
    sb            = new();
    quiet         = 1'b0;
    hold_cycles   = 0;
    bytes_sent    = 0;
    settings_used = 0;
    idle_cycles   = 0;
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values: everything passes straight through.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(ASC_CR, 1'b0);
    send_byte(ASC_LF, 1'b0);
    send_byte(ASC_TAB, 1'b1);

    // Every option except dropping CR: numbering, meta, caret, DEL and the added CR and LF.
    drain();
    c = '1;
    c.drop_cr = 1'b0;
    apply_cfg(c, 1'b1);
    mixed = '{ASC_LF, 8'h00, 8'h80, 8'h8D, 8'h8A, ASC_CR, ASC_LF, ASC_TAB,
              8'h89, ASC_DEL, 8'h1F, 8'h01, 8'hFF, ASC_SPACE};
    foreach (mixed[i]) begin
      send_byte(mixed[i], i == 13);
    end

    // Dropped CR with numbering: a CR at a line start emits only the number prefix and ends the line start.
    drain();
    c = '0;
    c.drop_cr = 1'b1;
    c.show_nonprinting = 1'b1;
    c.number_lines = 1'b1;
    apply_cfg(c, 1'b0);
    send_byte(ASC_CR, 1'b1);
    send_byte(ASC_CR, 1'b0);
    send_byte(ASC_TAB, 1'b0);
    send_byte(ASC_LF, 1'b0);
    send_byte(ASC_CR, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c = '1;
      end else begin
        c = cfg_t'(8'($urandom_range(0, 255)));
      end
      apply_cfg(c, $urandom_range(0, 1));
      quiet = (p >= RANDOM_PHASES - 2);
      // Holding the result side back fills the queues and stalls the input.
      if (p == 2) begin
        hold_cycles = LONG_HOLD;
      end
      repeat (PHASE_ITEMS) begin
        send_byte(pick_byte(), $urandom_range(0, 7) == 0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d input bytes under %0d register settings; %0d output bytes compared.",
             bytes_sent, settings_used, sb.checked);
    $display("Included NUL, DEL, meta bytes, dropped CRs, numbered lines and a long stall.");
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("** text_byte_visualizer: PASSED **");
    end else begin
      $display("** text_byte_visualizer: FAILED **");
    end
    $finish;
  end

endmodule
